>>> rtl/prony_series_stress_relaxation_macros.svh
// Assertion macros used by the port-level checker
`ifndef PRONY_SERIES_STRESS_RELAXATION_MACROS_SVH
`define PRONY_SERIES_STRESS_RELAXATION_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define PSR_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psr assertion failed");

// next-cycle implication
`define PSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psr assertion failed");

`endif

>>> rtl/psr_pkg.sv
// Shared types and constants of the Prony series stress relaxation block
`timescale 1ns / 1ps
package psr_pkg;

  localparam int unsigned MaxElementsDef = 3;
  localparam int unsigned Components     = 9;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 32;

  localparam logic [63:0] SmallRatio = 64'd4295;
  localparam logic [32:0] OneQ32     = 33'h1_0000_0000;
  localparam logic [32:0] ExpNegOne  = 33'd1580030169;
  localparam logic [3:0]  ExpTerms   = 4'd14;
  localparam logic [31:0] ExpMaxInt  = 32'd23;
  localparam logic [16:0] OneQ16     = 17'd65536;

  typedef enum logic [2:0] {
    RegCount   = 3'd0,
    RegWeight0 = 3'd1,
    RegTau0    = 3'd2,
    RegWeight1 = 3'd3,
    RegTau1    = 3'd4,
    RegWeight2 = 3'd5,
    RegTau2    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic start;
    logic narrow;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/psr_div.sv
// Radix-2 restoring divider, 64-bit or 33-bit dividend, one bit per cycle
`timescale 1ns / 1ps
module psr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psr_pkg::div_req_t req_i,
  input  logic [63:0]       dividend_i,
  input  logic [63:0]       divisor_i,
  output psr_pkg::div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] num_q, num_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] quot_q, quot_d;
  logic [63:0] den_q, den_d;
  logic [64:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q[63:0], num_q[63]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      num_d  = req_i.narrow ? {dividend_i[32:0], 31'd0} : dividend_i;
      cnt_d  = req_i.narrow ? 7'd33 : 7'd64;
      rem_d  = '0;
      quot_d = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      num_d  = {num_q[62:0], 1'b0};
      rem_d  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quot_d = {quot_q[62:0], ge};
      cnt_d  = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;

endmodule

>>> rtl/prony_series_stress_relaxation.sv
// Top level of the Prony series stress relaxation block
//
//  channel | direction | handshake              | payload
//  cfg     | in        | cfg_we_i               | cfg_index_i, cfg_wdata_i
//  in      | in        | in_valid_i / in_ready_o| component, stresses, time step
//  out     | out       | out_valid_o/out_ready_i| component, total, tangent
//
// One word: an accept step, a check of each element slot and one more, then per element
// with a nonzero relaxation time a ratio division, then beta and the update.
// A ratio of 4295 LSB or more adds a beta division and, below 23.0, 14 series terms,
// each a multiply and a division, and one product per exp(-1) factor; a final multiply
// and set form the result. One 64-bit radix-2 divider, one 33x33 multiplier.
// In_ready is high only in idle; a stalled output only holds the final step.
// Reset clears the element stress registers at once.
`timescale 1ns / 1ps
module prony_series_stress_relaxation #(
  parameter int unsigned MaxElements = psr_pkg::MaxElementsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [psr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [psr_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [3:0]                   component_i,
  input  logic signed [31:0]           equilibrium_stress_i,
  input  logic signed [31:0]           stress_increment_i,
  input  logic [31:0]                  time_step_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [3:0]                   out_component_o,
  output logic signed [31:0]           total_stress_o,
  output logic signed [19:0]           tangent_scale_o
);

  localparam int unsigned Depth = MaxElements * psr_pkg::Components;
  localparam int unsigned IdxW  = $clog2(Depth);

  typedef enum logic [16:0] {
    StIdle  = 17'h00001,
    StElem  = 17'h00002,
    StDivR  = 17'h00004,
    StEMul  = 17'h00008,
    StEDst  = 17'h00010,
    StEDiv  = 17'h00020,
    StEPow  = 17'h00040,
    StEPw2  = 17'h00080,
    StBfSt  = 17'h00100,
    StBfDiv = 17'h00200,
    StBMul  = 17'h00400,
    StBSet  = 17'h00800,
    StQA1   = 17'h01000,
    StQA2   = 17'h02000,
    StQB    = 17'h04000,
    StTMul  = 17'h08000,
    StTSet  = 17'h10000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]  count_q;
  logic [16:0] weight_q [3];
  logic [31:0] tau_q [3];

  logic signed [31:0] store_q [Depth];

  logic [1:0]         cnt_q, cnt_d, elem_q, elem_d;
  logic [3:0]         comp_q, comp_d;
  logic signed [31:0] eq_q, eq_d, inc_q, inc_d, old_q, old_d;
  logic [31:0]        dt_q, dt_d;
  logic signed [20:0] factor_q, factor_d;
  logic [19:0]        sbeta_q, sbeta_d;
  logic signed [35:0] esum_q, esum_d, qacc_q, qacc_d;
  logic [63:0]        r_q, r_d;
  logic [32:0]        alpha_q, alpha_d, bf_q, bf_d, beta_q, beta_d, term_q, term_d;
  logic signed [34:0] acc_q, acc_d;
  logic [3:0]         k_q, k_d;
  logic [4:0]         n_q, n_d;
  logic [65:0]        prod_q;
  logic [32:0]        mul_a, mul_b;

  logic               out_valid_q, out_valid_d;
  logic [3:0]         ocomp_q, ocomp_d;
  logic signed [31:0] otot_q, otot_d;
  logic signed [19:0] otan_q, otan_d;

  psr_pkg::div_req_t div_req;
  psr_pkg::div_rsp_t div_rsp;
  logic [63:0]       div_num, div_den;

  logic [1:0]         cnt_eff;
  logic [18:0]        sum_w;
  logic [16:0]        w_sel;
  logic [31:0]        tau_sel;
  logic [IdxW-1:0]    idx;
  logic               comp_ok;
  logic [63:0]        r_fix;
  logic [32:0]        term_new, acc_clamp, oma;
  logic signed [34:0] acc_step;
  logic [31:0]        old_mag, inc_mag, eq_mag;
  logic [20:0]        fac_mag;
  logic [32:0]        ma;
  logic [33:0]        mb, tm;
  logic signed [35:0] qa, qb, qs, ts, tot;
  logic signed [31:0] qsat, tot_sat;
  logic signed [21:0] tang;
  logic signed [19:0] tang_sat;
  logic               accept;

  assign accept     = in_ready_o && in_valid_i;
  assign in_ready_o = (state_q == StIdle);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      weight_q <= '{default: '0};
      tau_q    <= '{default: '0};
    end else if (cfg_we_i) begin
      unique case (psr_pkg::cfg_reg_e'(cfg_index_i))
        psr_pkg::RegCount:   count_q     <= cfg_wdata_i[1:0];
        psr_pkg::RegWeight0: weight_q[0] <= cfg_wdata_i[16:0];
        psr_pkg::RegTau0:    tau_q[0]    <= cfg_wdata_i;
        psr_pkg::RegWeight1: weight_q[1] <= cfg_wdata_i[16:0];
        psr_pkg::RegTau1:    tau_q[1]    <= cfg_wdata_i;
        psr_pkg::RegWeight2: weight_q[2] <= cfg_wdata_i[16:0];
        psr_pkg::RegTau2:    tau_q[2]    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cnt_eff = (32'(count_q) > MaxElements) ? 2'(MaxElements) : count_q;
  assign sum_w   = ((cnt_eff > 2'd0) ? {2'b0, weight_q[0]} : 19'd0)
                 + ((cnt_eff > 2'd1) ? {2'b0, weight_q[1]} : 19'd0)
                 + ((cnt_eff > 2'd2) ? {2'b0, weight_q[2]} : 19'd0);

  always_comb begin
    unique case (elem_q)
      2'd0:    begin w_sel = weight_q[0]; tau_sel = tau_q[0]; end
      2'd1:    begin w_sel = weight_q[1]; tau_sel = tau_q[1]; end
      default: begin w_sel = weight_q[2]; tau_sel = tau_q[2]; end
    endcase
  end

  assign comp_ok = comp_q < 4'(psr_pkg::Components);
  assign idx     = IdxW'(elem_q) * IdxW'(psr_pkg::Components) + IdxW'(comp_q);

  // magnitudes for the sign-magnitude products
  assign old_mag = old_q[31] ? (~old_q + 32'd1) : old_q;
  assign inc_mag = inc_q[31] ? (~inc_q + 32'd1) : inc_q;
  assign eq_mag  = eq_q[31] ? (~eq_q + 32'd1) : eq_q;
  assign fac_mag = factor_q[20] ? (~factor_q + 21'd1) : factor_q;

  // shared multiplier
  always_comb begin
    unique case (state_q)
      StEMul:  begin mul_a = term_q;           mul_b = {1'b0, r_q[31:0]}; end
      StEPow:  begin mul_a = alpha_q;          mul_b = psr_pkg::ExpNegOne; end
      StBMul:  begin mul_a = {16'd0, w_sel};   mul_b = bf_q; end
      StQA1:   begin mul_a = {1'b0, old_mag};  mul_b = {1'b0, alpha_q[31:0]}; end
      StQA2:   begin mul_a = {1'b0, inc_mag};  mul_b = {1'b0, beta_q[31:0]}; end
      default: begin mul_a = {1'b0, eq_mag};   mul_b = {12'd0, fac_mag}; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // shared divider
  assign oma = psr_pkg::OneQ32 - alpha_q;

  always_comb begin
    div_req.start  = 1'b0;
    div_req.narrow = 1'b0;
    unique case (state_q)
      StEDst: begin
        div_num = {31'd0, prod_q[64:32]};
        div_den = {60'd0, k_q};
      end
      StBfSt: begin
        div_num = (alpha_q == 33'd0) ? '1 : {oma[31:0], 32'd0};
        div_den = r_q;
      end
      default: begin
        div_num = {dt_q, 32'd0};
        div_den = {32'd0, tau_sel};
      end
    endcase
    if (state_q == StEDst) begin
      div_req.start  = 1'b1;
      div_req.narrow = 1'b1;
    end
    if (state_q == StBfSt) div_req.start = 1'b1;
    if (state_q == StElem && elem_q != cnt_q && tau_sel != 32'd0) div_req.start = 1'b1;
  end

  psr_div u_div (
    .clk_i,
    .rst_ni,
    .req_i      (div_req),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .rsp_o      (div_rsp)
  );

  // arithmetic between steps
  assign r_fix    = (div_rsp.quotient == 64'd0) ? 64'd1 : div_rsp.quotient;
  assign term_new = div_rsp.quotient[32:0];
  assign acc_step = k_q[0] ? (acc_q - $signed({2'b0, term_new}))
                           : (acc_q + $signed({2'b0, term_new}));
  assign acc_clamp = acc_step[34] ? 33'd0
                   : (acc_step > $signed({2'b0, psr_pkg::OneQ32})) ? psr_pkg::OneQ32
                   : acc_step[32:0];

  assign ma = {1'b0, prod_q[63:32]} + (alpha_q[32] ? {1'b0, old_mag} : 33'd0);
  assign qa = old_q[31] ? -$signed({3'b0, ma}) : $signed({3'b0, ma});
  assign mb = {2'b0, prod_q[63:32]} + (beta_q[32] ? {2'b0, inc_mag} : 34'd0);
  assign qb = inc_q[31] ? -$signed({2'b0, mb}) : $signed({2'b0, mb});
  assign qs = qacc_q + qb;
  assign qsat = (qs > 36'sd2147483647) ? 32'sh7FFF_FFFF
              : (qs < -36'sd2147483648) ? 32'sh8000_0000 : qs[31:0];

  assign tm  = prod_q[49:16];
  assign ts  = (eq_q[31] ^ factor_q[20]) ? -$signed({2'b0, tm}) : $signed({2'b0, tm});
  assign tot = ts + esum_q;
  assign tot_sat = (tot > 36'sd2147483647) ? 32'sh7FFF_FFFF
                 : (tot < -36'sd2147483648) ? 32'sh8000_0000 : tot[31:0];
  assign tang = {factor_q[20], factor_q} + $signed({2'b0, sbeta_q});
  assign tang_sat = (tang > 22'sd524287) ? 20'sh7FFFF
                  : (tang < -22'sd524288) ? 20'sh80000 : tang[19:0];

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    elem_d      = elem_q;
    comp_d      = comp_q;
    eq_d        = eq_q;
    inc_d       = inc_q;
    dt_d        = dt_q;
    old_d       = old_q;
    factor_d    = factor_q;
    sbeta_d     = sbeta_q;
    esum_d      = esum_q;
    qacc_d      = qacc_q;
    r_d         = r_q;
    alpha_d     = alpha_q;
    bf_d        = bf_q;
    beta_d      = beta_q;
    term_d      = term_q;
    acc_d       = acc_q;
    k_d         = k_q;
    n_d         = n_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ocomp_d     = ocomp_q;
    otot_d      = otot_q;
    otan_d      = otan_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          comp_d   = component_i;
          eq_d     = equilibrium_stress_i;
          inc_d    = stress_increment_i;
          dt_d     = time_step_i;
          cnt_d    = cnt_eff;
          elem_d   = 2'd0;
          factor_d = $signed({4'b0, psr_pkg::OneQ16}) - $signed({2'b0, sum_w});
          sbeta_d  = '0;
          esum_d   = '0;
          state_d  = StElem;
        end
      end
      StElem: begin
        if (elem_q == cnt_q) state_d = StTMul;
        else if (tau_sel == 32'd0) elem_d = elem_q + 2'd1;
        else state_d = StDivR;
      end
      StDivR: begin
        if (div_rsp.done) begin
          r_d = r_fix;
          if (r_fix < psr_pkg::SmallRatio) begin
            alpha_d = psr_pkg::OneQ32 - r_fix[32:0];
            bf_d    = psr_pkg::OneQ32 - {1'b0, r_fix[32:1]};
            state_d = StBMul;
          end else if (r_fix[63:32] >= psr_pkg::ExpMaxInt) begin
            alpha_d = '0;
            state_d = StBfSt;
          end else begin
            acc_d   = $signed({2'b0, psr_pkg::OneQ32});
            term_d  = psr_pkg::OneQ32;
            k_d     = 4'd1;
            n_d     = r_fix[36:32];
            state_d = StEMul;
          end
        end
      end
      StEMul: state_d = StEDst;
      StEDst: state_d = StEDiv;
      StEDiv: begin
        if (div_rsp.done) begin
          term_d = term_new;
          acc_d  = acc_step;
          if (k_q == psr_pkg::ExpTerms) begin
            alpha_d = acc_clamp;
            state_d = StEPow;
          end else begin
            k_d     = k_q + 4'd1;
            state_d = StEMul;
          end
        end
      end
      StEPow: state_d = (n_q == 5'd0) ? StBfSt : StEPw2;
      StEPw2: begin
        alpha_d = prod_q[64:32];
        n_d     = n_q - 5'd1;
        state_d = StEPow;
      end
      StBfSt: state_d = StBfDiv;
      StBfDiv: begin
        if (div_rsp.done) begin
          bf_d = (div_rsp.quotient > {31'd0, psr_pkg::OneQ32}) ? psr_pkg::OneQ32
                                                             : div_rsp.quotient[32:0];
          state_d = StBMul;
        end
      end
      StBMul: state_d = StBSet;
      StBSet: begin
        beta_d  = prod_q[48:16];
        sbeta_d = sbeta_q + {2'b0, prod_q[49:32]};
        old_d   = comp_ok ? store_q[idx] : 32'sd0;
        state_d = StQA1;
      end
      StQA1: state_d = StQA2;
      StQA2: begin
        qacc_d  = qa;
        state_d = StQB;
      end
      StQB: begin
        esum_d  = esum_q + 36'(qsat);
        elem_d  = elem_q + 2'd1;
        state_d = StElem;
      end
      StTMul: state_d = StTSet;
      StTSet: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ocomp_d     = comp_q;
          otot_d      = tot_sat;
          otan_d      = tang_sat;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      elem_q      <= '0;
      k_q         <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      elem_q      <= elem_d;
      k_q         <= k_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    comp_q   <= comp_d;
    eq_q     <= eq_d;
    inc_q    <= inc_d;
    dt_q     <= dt_d;
    old_q    <= old_d;
    factor_q <= factor_d;
    sbeta_q  <= sbeta_d;
    esum_q   <= esum_d;
    qacc_q   <= qacc_d;
    r_q      <= r_d;
    alpha_q  <= alpha_d;
    bf_q     <= bf_d;
    beta_q   <= beta_d;
    term_q   <= term_d;
    acc_q    <= acc_d;
    ocomp_q  <= ocomp_d;
    otot_q   <= otot_d;
    otan_q   <= otan_d;
  end

  // element stress store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '{default: '0};
    end else if (state_q == StQB && comp_ok) begin
      store_q[idx] <= qsat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_component_o = ocomp_q;
  assign total_stress_o  = otot_q;
  assign tangent_scale_o = otan_q;

endmodule

>>> rtl/psr_checker.sv
// Port-level checker for the Prony series stress relaxation block
`timescale 1ns / 1ps
`include "prony_series_stress_relaxation_macros.svh"
module psr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [3:0]                   out_component_o,
  input logic signed [31:0]           total_stress_o,
  input logic signed [19:0]           tangent_scale_o
);

  `PSR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_component_o) && $stable(total_stress_o) && $stable(tangent_scale_o))
  `PSR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `PSR_ASSERT(a_result_at_idle, $rose(out_valid_o), in_ready_o)
  `PSR_ASSERT_NEXT(a_idle_holds, in_ready_o && !in_valid_i, in_ready_o)

endmodule

bind prony_series_stress_relaxation psr_checker u_psr_checker (.*);

>>> tb/sv/prony_series_stress_relaxation_tb.sv
// Self-checking testbench of the Prony series stress relaxation block
`timescale 1ns / 1ps
module prony_series_stress_relaxation_tb;

  localparam longint unsigned Q32 = 64'h1_0000_0000;
  localparam longint unsigned CycleLimit = 64'd40_000_000;
  localparam int PhaseItems = 140;

  typedef struct {
    logic [3:0]         comp;
    logic signed [31:0] eq;
    logic signed [31:0] inc;
    logic [31:0]        dt;
  } word_t;

  typedef struct {
    logic [3:0]         comp;
    logic signed [31:0] total;
    logic signed [19:0] tangent;
  } result_t;

  typedef struct {
    bit      typed;
    word_t   w;
    result_t r;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [psr_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [psr_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [3:0] component_i = '0;
  logic signed [31:0] equilibrium_stress_i = '0;
  logic signed [31:0] stress_increment_i = '0;
  logic [31:0] time_step_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [3:0] out_component_o;
  logic signed [31:0] total_stress_o;
  logic signed [19:0] tangent_scale_o;

  logic [1:0]  elem_count;
  logic [16:0] weight [3];
  logic [31:0] tau [3];
  logic signed [31:0] elem_stress [3][9];

  result_t expected_q [$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  longint unsigned cycles = 0;
  int stall_left = 0;

  always #4 clk_i = ~clk_i;

  prony_series_stress_relaxation u_top (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("prony_series_stress_relaxation: mismatch");
      $finish;
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // stretches without new stalls whenever bit 11 of the cycle counter is clear
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (cycles[11] && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("ERROR %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report("unexpected word, component", out_component_o, -1);
      end else begin
        e = expected_q.pop_front();
        words_checked++;
        if (out_component_o !== e.comp) report("component", out_component_o, e.comp);
        if (total_stress_o !== e.total) report("total_stress", total_stress_o, e.total);
        if (tangent_scale_o !== e.tangent)
          report("tangent_scale", tangent_scale_o, e.tangent);
      end
    end
  end

  function automatic longint unsigned q32_mul(longint unsigned a, longint unsigned b);
    if (b == Q32) return a;
    if (a == Q32) return b;
    return (a * b) >> 32;
  endfunction

  function automatic longint unsigned decay_frac(longint unsigned x);
    longint acc;
    longint unsigned term;
    acc = longint'(Q32);
    term = Q32;
    for (int k = 1; k <= 14; k++) begin
      term = q32_mul(term, x) / k;
      if (k % 2) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(Q32)) acc = longint'(Q32);
    return longint'(acc);
  endfunction

  function automatic longint unsigned decay(longint unsigned r);
    longint unsigned n, res, e1;
    n = r >> 32;
    if (n >= 23) return 0;
    res = decay_frac(r & 64'hFFFF_FFFF);
    e1 = decay_frac(Q32);
    for (longint unsigned i = 0; i < n; i++) res = q32_mul(res, e1);
    return res;
  endfunction

  function automatic longint scale_q32(longint a, longint unsigned b);
    longint unsigned mag, m;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    m = mag * (b >> 32) + ((mag * (b & 64'hFFFF_FFFF)) >> 32);
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic result_t relax_step(word_t w);
    result_t res;
    bit in_range;
    longint sum_w, factor, sum_beta, elem_sum, old, q, total;
    longint unsigned r, alpha, bf, beta, oma, dt;
    in_range = w.comp < psr_pkg::Components;
    dt = longint'(w.dt);
    sum_w = 0;
    sum_beta = 0;
    elem_sum = 0;
    for (int i = 0; i < elem_count; i++) sum_w += weight[i];
    factor = 65536 - sum_w;
    for (int i = 0; i < elem_count; i++) begin
      if (tau[i] == 0) continue;
      r = (dt << 32) / longint'(tau[i]);
      if (r == 0) r = 1;
      if (r < psr_pkg::SmallRatio) begin
        alpha = Q32 - r + ((r * r) >> 33);
        bf = Q32 - (r >> 1) + ((r * r / 6) >> 32);
      end else begin
        alpha = decay(r);
        oma = Q32 - alpha;
        bf = ((oma >= Q32) ? 64'hFFFF_FFFF_FFFF_FFFF : (oma << 32)) / r;
        if (bf > Q32) bf = Q32;
      end
      beta = (longint'(weight[i]) * bf) >> 16;
      old = in_range ? longint'(elem_stress[i][w.comp]) : 0;
      q = clip(scale_q32(old, alpha) + scale_q32(longint'(w.inc), beta),
               -64'sd2147483648, 64'sd2147483647);
      if (in_range) elem_stress[i][w.comp] = q[31:0];
      elem_sum += q;
      sum_beta += longint'(beta >> 16);
    end
    total = (longint'(w.eq) * factor) / 65536 + elem_sum;
    res.comp = w.comp;
    res.total = clip(total, -64'sd2147483648, 64'sd2147483647);
    res.tangent = clip(factor + sum_beta, -524288, 524287);
    return res;
  endfunction

  task automatic send_word(word_t w, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    component_i <= w.comp;
    equilibrium_stress_i <= w.eq;
    stress_increment_i <= w.inc;
    time_step_i <= w.dt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic configure(logic [1:0] cnt, logic [16:0] w[3], logic [31:0] t[3]);
    cfg_we_i <= 1'b1;
    cfg_index_i <= psr_pkg::RegCount;
    cfg_wdata_i <= 32'(cnt);
    @(posedge clk_i);
    for (int i = 0; i < 3; i++) begin
      cfg_index_i <= psr_pkg::cfg_reg_e'(psr_pkg::RegWeight0 + 2 * i);
      cfg_wdata_i <= 32'(w[i]);
      @(posedge clk_i);
      cfg_index_i <= psr_pkg::cfg_reg_e'(psr_pkg::RegTau0 + 2 * i);
      cfg_wdata_i <= t[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    elem_count = cnt;
    weight = w;
    tau = t;
  endtask

  function automatic word_t rand_word();
    word_t w;
    int p;
    p = $urandom_range(0, 99);
    w.comp = (p < 88) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
    w.eq = $urandom_range(0, 3) == 0 ? 32'($signed($urandom_range(0, 2000000)) - 1000000)
                                     : $urandom;
    w.inc = $urandom_range(0, 2) == 0 ? 32'($signed($urandom_range(0, 600000)) - 300000)
                                      : $urandom;
    case ($urandom_range(0, 5))
      0: w.dt = $urandom_range(0, 8);
      1: w.dt = $urandom_range(0, 65535);
      2: w.dt = $urandom_range(0, 32'h0020_0000);
      3: w.dt = $urandom >> $urandom_range(0, 31);
      default: w.dt = $urandom;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rand_tau();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 16);
      3: return $urandom_range(1, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(0, 4))
      0: return 17'd0;
      1: return 17'd65536;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  row_t rows [] = '{
    '{1, '{4'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h0}, '{4'd0, 32'sh7FFF_FFFF, 20'sd65536}},
    '{1, '{4'd8, 32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF},
         '{4'd8, 32'sh8000_0000, 20'sd65536}},
    '{1, '{4'd9, -32'sd1, 32'sd5, 32'h1_0000}, '{4'd9, -32'sd1, 20'sd65536}},
    '{1, '{4'd15, 32'sd0, -32'sd7, 32'h5555_AAAA}, '{4'd15, 32'sd0, 20'sd65536}},
    '{1, '{4'd4, 32'h5555_AAAA, 32'hAAAA_5555, 32'hAAAA_5555},
         '{4'd4, 32'h5555_AAAA, 20'sd65536}},
    '{0, '{4'd0, 32'sh0001_0000, 32'sh0002_0000, 32'h0}, '{4'd0, '0, '0}},
    '{0, '{4'd0, 32'sh0001_0000, 32'sh0002_0000, 32'h1}, '{4'd0, '0, '0}},
    '{0, '{4'd0, 32'sh0001_0000, 32'sh7FFF_FFFF, 32'h1_0000}, '{4'd0, '0, '0}},
    '{0, '{4'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h8000}, '{4'd0, '0, '0}},
    '{0, '{4'd1, 32'sh8000_0000, 32'sh8000_0000, 32'h0016_8000}, '{4'd1, '0, '0}},
    '{0, '{4'd1, 32'sh8000_0000, 32'sh8000_0000, 32'h0020_0000}, '{4'd1, '0, '0}},
    '{0, '{4'd2, 32'sd12345, -32'sd99999, 32'hFFFF_FFFF}, '{4'd2, '0, '0}},
    '{0, '{4'd9, 32'sd1000, 32'sh4000_0000, 32'h1_0000}, '{4'd9, '0, '0}},
    '{0, '{4'd15, -32'sd1000, 32'sh4000_0000, 32'h0}, '{4'd15, '0, '0}},
    '{0, '{4'd8, 32'sd0, 32'sh0100_0000, 32'h3_0000}, '{4'd8, '0, '0}},
    '{0, '{4'd8, 32'sd0, -32'sd1, 32'h3_0000}, '{4'd8, '0, '0}}
  };

  initial begin
    logic [16:0] w [3];
    logic [31:0] t [3];
    elem_count = 0;
    weight = '{default: '0};
    tau = '{default: '0};
    elem_stress = '{default: '{default: '0}};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (i > 0 && !rows[i].typed && rows[i - 1].typed) begin
        drain();
        w = '{17'd20000, 17'd65536, 17'd30000};
        t = '{32'h0001_0000, 32'd0, 32'hFFFF_FFFF};
        configure(2'd3, w, t);
      end
      expected_q.push_back(rows[i].typed ? rows[i].r : relax_step(rows[i].w));
      send_word(rows[i].w, pick_gap());
    end

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph)
        0: begin
          w = '{17'd65536, 17'd65536, 17'd65536};
          t = '{32'h1, 32'hFFFF_FFFF, 32'h0008_0000};
          configure(2'd3, w, t);
        end
        1: begin
          w = '{17'd0, 17'd0, 17'd0};
          t = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
          configure(2'd1, w, t);
        end
        2: begin
          w = '{17'd40000, 17'd1, 17'd65536};
          t = '{32'h0000_8000, 32'h0004_0000, 32'd0};
          configure(2'd0, w, t);
        end
        default: begin
          foreach (w[i]) w[i] = rand_weight();
          foreach (t[i]) t[i] = rand_tau();
          configure(2'($urandom_range(0, 3)), w, t);
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        word_t rw;
        rw = rand_word();
        expected_q.push_back(relax_step(rw));
        send_word(rw, pick_gap());
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d words (directed table plus 10 register settings), checked %0d results.",
             words_sent, words_checked);
    $display("Covered time step floor, small ratio, full decay, inactive elements, %s",
             "out-of-range components and saturation.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("prony_series_stress_relaxation: match");
    end else begin
      $display("prony_series_stress_relaxation: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/psr_pkg.sv
rtl/psr_div.sv
rtl/prony_series_stress_relaxation.sv
rtl/psr_checker.sv
tb/sv/prony_series_stress_relaxation_tb.sv
